[hdl/huffman_tree_bit_decoder_macros.svh]
// Assertion macros used by the checker file.
`ifndef HUFFMAN_TREE_BIT_DECODER_MACROS_SVH
`define HUFFMAN_TREE_BIT_DECODER_MACROS_SVH

// Check a consequence in the cycle after the trigger.
`define HTD_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

// Check a consequence in the same cycle as the trigger.
`define HTD_ASSERT_SAME(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cons)) \
		else $error(msg);

`endif

[hdl/htd_pkg.sv]
`timescale 1ns / 1ps

package htd_pkg;

	localparam int MAX_NODES = 512;
	localparam int IDX_W     = 9;
	localparam int SYM_W     = 8;
	localparam int BYTE_W    = 8;
	localparam int NBITS_W   = 4;

	localparam logic [NBITS_W-1:0] BYTE_BITS = NBITS_W'(BYTE_W);

	localparam logic KIND_NODE = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [IDX_W-1:0]   node_index;
		logic [IDX_W-1:0]   left_child;
		logic [IDX_W-1:0]   right_child;
		logic               is_leaf;
		logic [SYM_W-1:0]   leaf_symbol;
		logic [BYTE_W-1:0]  data_byte;
		logic [NBITS_W-1:0] valid_bits;
	} in_word_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last_of_run;
	} out_word_t;

	typedef struct packed {
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
		logic             leaf;
		logic [SYM_W-1:0] sym;
	} node_entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		node_entry_t      entry;
	} node_wr_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} node_rd_t;

endpackage

[hdl/huffman_tree_bit_decoder.sv]
// Channel   Signals                        Word
// in        in_valid / in_ready            htd_pkg::in_word_t
// out       out_valid / out_ready          htd_pkg::out_word_t
// cfg       cfg_we / cfg_wdata             root node index, 9 bits
//
// A data byte gives s symbols for n used bits (n at most 8, s at most n), and each coded
// bit needs one node table read; a symbol always uses at least one coded bit.
// Reset sets the root and the walk position to entry 0; the node table is not cleared.
// A full output register stalls the walk at the next symbol; the input waits until
// the byte's last symbol is handed to the output register.
`timescale 1ns / 1ps

module huffman_tree_bit_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  htd_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output htd_pkg::out_word_t out_data,
	input  logic               cfg_we,
	input  logic [8:0]         cfg_wdata
);
	import htd_pkg::*;

	node_wr_t    wr;
	node_rd_t    rd;
	node_entry_t rd_data;

	htd_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.wr        (wr),
		.rd        (rd),
		.rd_data   (rd_data)
	);

	htd_node_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

endmodule

[hdl/htd_node_store.sv]
`timescale 1ns / 1ps

module htd_node_store (
	input  logic                clk,
	input  htd_pkg::node_wr_t   wr,
	input  htd_pkg::node_rd_t   rd,
	output htd_pkg::node_entry_t rd_data
);
	import htd_pkg::*;

	node_entry_t mem [MAX_NODES];
	node_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en && (int'(wr.addr) < MAX_NODES)) begin
			mem[wr.addr] <= wr.entry;
		end
	end

	// out-of-table reads see an empty inner node
	always_ff @(posedge clk) begin
		if (rd.en) begin
			if (int'(rd.addr) < MAX_NODES) begin
				rd_data_q <= mem[rd.addr];
			end else begin
				rd_data_q <= '0;
			end
		end
	end

	assign rd_data = rd_data_q;

endmodule

[hdl/htd_walker.sv]
`timescale 1ns / 1ps

module htd_walker (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  htd_pkg::in_word_t    in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output htd_pkg::out_word_t   out_data,
	input  logic                 cfg_we,
	input  logic [8:0]           cfg_wdata,
	output htd_pkg::node_wr_t    wr,
	output htd_pkg::node_rd_t    rd,
	input  htd_pkg::node_entry_t rd_data
);
	import htd_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_STEP
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   root_q;
	logic [IDX_W-1:0]   walk_q;
	logic [BYTE_W-1:0]  bits_q;
	logic [NBITS_W-1:0] cnt_q;
	logic               chk_q;
	logic [SYM_W-1:0]   hold_q;
	logic               hold_vld_q;
	logic               out_valid_q;
	out_word_t          out_data_q;

	logic               accept;
	logic               slot_free;
	logic               leaf_hit;
	logic               out_push;
	logic [IDX_W-1:0]   child;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign leaf_hit  = chk_q && rd_data.leaf;
	assign child     = bits_q[BYTE_W-1] ? rd_data.right : rd_data.left;
	assign out_push  = (state_q == ST_STEP) && hold_vld_q && slot_free
		&& (leaf_hit || (cnt_q == '0));

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		wr.en          = accept && (in_data.kind == KIND_NODE);
		wr.addr        = in_data.node_index;
		wr.entry.left  = in_data.left_child;
		wr.entry.right = in_data.right_child;
		wr.entry.leaf  = in_data.is_leaf;
		wr.entry.sym   = in_data.leaf_symbol;
	end

	always_comb begin
		rd.en   = 1'b0;
		rd.addr = walk_q;
		case (state_q)
			ST_IDLE: begin
				rd.en = accept && (in_data.kind == KIND_DATA);
			end
			ST_STEP: begin
				if (leaf_hit) begin
					rd.en   = !hold_vld_q || slot_free;
					rd.addr = root_q;
				end else if (cnt_q != '0) begin
					rd.en   = 1'b1;
					rd.addr = child;
				end
			end
			default: begin
				rd.en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			root_q      <= '0;
			walk_q      <= '0;
			cnt_q       <= '0;
			chk_q       <= 1'b0;
			hold_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready && !out_push) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				root_q <= cfg_wdata;
				walk_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (in_data.kind == KIND_DATA)) begin
						bits_q  <= in_data.data_byte;
						cnt_q   <= (in_data.valid_bits > BYTE_BITS) ? BYTE_BITS
							: in_data.valid_bits;
						chk_q   <= 1'b0;
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (leaf_hit) begin
						// push the older symbol, keep the new one until we know it is last
						if (!hold_vld_q || slot_free) begin
							if (hold_vld_q) begin
								out_valid_q            <= 1'b1;
								out_data_q.symbol      <= hold_q;
								out_data_q.last_of_run <= 1'b0;
							end
							hold_q     <= rd_data.sym;
							hold_vld_q <= 1'b1;
							walk_q     <= root_q;
							chk_q      <= 1'b0;
						end
					end else if (cnt_q != '0) begin
						walk_q <= child;
						bits_q <= {bits_q[BYTE_W-2:0], 1'b0};
						cnt_q  <= cnt_q - NBITS_W'(1);
						chk_q  <= 1'b1;
					end else if (hold_vld_q) begin
						if (slot_free) begin
							out_valid_q            <= 1'b1;
							out_data_q.symbol      <= hold_q;
							out_data_q.last_of_run <= 1'b1;
							hold_vld_q             <= 1'b0;
							state_q                <= ST_IDLE;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[hdl/htd_checker.sv]
`timescale 1ns / 1ps
`include "huffman_tree_bit_decoder_macros.svh"

module htd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input htd_pkg::in_word_t  in_data,
	input logic               out_valid,
	input logic               out_ready,
	input htd_pkg::out_word_t out_data
);
	import htd_pkg::*;

	`HTD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output word dropped or changed while stalled")
	`HTD_ASSERT_NEXT(a_node_write_idle, in_valid && in_ready && (in_data.kind == KIND_NODE), in_ready, "node write left the block busy")
	`HTD_ASSERT_NEXT(a_data_busy, in_valid && in_ready && (in_data.kind == KIND_DATA), !in_ready, "data byte accepted without starting a walk")
	`HTD_ASSERT_SAME(a_run_open, out_valid && !out_data.last_of_run, !in_ready, "input taken while a byte still has symbols to deliver")

endmodule

bind huffman_tree_bit_decoder htd_checker u_chk (.*);
